// ----- hdl/multilevel_feedback_dispatcher_macros.svh -----
// Assertion macros used by the dispatcher back end.
`ifndef MULTILEVEL_FEEDBACK_DISPATCHER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_DISPATCHER_MACROS_SVH

// Checked on every clock edge outside reset.
`define MFD_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MFD_CHECK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mfd_pkg.sv -----
`default_nettype none

package mfd_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int LEVELS_DEF      = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PRINTERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SCANNERS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_MODEMS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DRIVES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MEM_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM        = 3'd5;

  typedef enum logic {
    CMD_ENQUEUE  = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED       = 3'd0,
    ST_QUEUE_FULL     = 3'd1,
    ST_NONE_WAITING   = 3'd2,
    ST_COMPLETED      = 3'd3,
    ST_DEMOTED        = 3'd4,
    ST_REJECTED       = 3'd5,
    ST_REQUEUE_DROPPED = 3'd6
  } status_t;

  typedef enum logic {
    BK_IDLE    = 1'b0,
    BK_RESOLVE = 1'b1
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] arrival;
    logic [1:0]  level;
    logic [15:0] run_time;
    logic [9:0]  mem_request;
    logic [2:0]  want_printers;
    logic [2:0]  want_scanners;
    logic [2:0]  want_modems;
    logic [2:0]  want_drives;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] job_arrival;
    logic [1:0]  job_level;
    logic [15:0] job_remaining;
    logic [9:0]  job_memory;
    logic [2:0]  job_printers;
    logic [2:0]  job_scanners;
    logic [2:0]  job_modems;
    logic [2:0]  job_drives;
  } out_res_t;

  // One stored job record, 54 bits.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] run_time;
    logic [9:0]  mem;
    logic [2:0]  prn;
    logic [2:0]  scn;
    logic [2:0]  mdm;
    logic [2:0]  drv;
  } job_rec_t;

  localparam int JOB_W = $bits(job_rec_t);

  // Classified request as it waits between front and back.
  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] level;
    job_rec_t   job;
  } q_req_t;

  typedef struct packed {
    logic [2:0] total_printers;
    logic [2:0] total_scanners;
    logic [2:0] total_modems;
    logic [2:0] total_drives;
    logic [9:0] user_memory_limit;
    logic [7:0] quantum;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/mfd_ram.sv -----
`default_nettype none

module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/mfd_front.sv -----
`default_nettype none

module mfd_front #(
  parameter int LEVELS = mfd_pkg::LEVELS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire mfd_pkg::in_req_t in_req,
  output logic                  q_valid,
  output mfd_pkg::q_req_t       q_req,
  input  wire logic             q_pop
);

  mfd_pkg::q_req_t ent_r [2];
  mfd_pkg::q_req_t cls;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;

  // Classify: clamp the level to the deepest level and repack the job.
  always_comb begin
    cls.cmd          = in_req.cmd;
    cls.level        = in_req.level;
    if (int'(in_req.level) > LEVELS - 1) begin
      cls.level = 2'(LEVELS - 1);
    end
    cls.job.arrival  = in_req.arrival;
    cls.job.run_time = in_req.run_time;
    cls.job.mem      = in_req.mem_request;
    cls.job.prn      = in_req.want_printers;
    cls.job.scn      = in_req.want_scanners;
    cls.job.mdm      = in_req.want_modems;
    cls.job.drv      = in_req.want_drives;
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mfd_back.sv -----
`default_nettype none

`include "multilevel_feedback_dispatcher_macros.svh"

module mfd_back #(
  parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH_DEF,
  parameter int LEVELS      = mfd_pkg::LEVELS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mfd_pkg::cfg_t    cfg,
  input  wire logic             q_valid,
  input  wire mfd_pkg::q_req_t  q_req,
  output logic                  q_pop,
  output logic                  out_valid,
  output mfd_pkg::out_res_t     out_res
);

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

  mfd_pkg::back_state_t state_r, state_nxt;

  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] head_nxt [LEVELS];
  logic [IDX_W-1:0] tail_r [LEVELS];
  logic [IDX_W-1:0] tail_nxt [LEVELS];
  logic [CNT_W-1:0] cnt_r [LEVELS];
  logic [CNT_W-1:0] cnt_nxt [LEVELS];
  logic [LVL_W-1:0] lvl_r, lvl_nxt;

  logic              out_valid_r, out_valid_nxt;
  mfd_pkg::out_res_t out_res_r, out_res_nxt;

  logic [LVL_W-1:0]  first_lvl;
  logic              any_waiting;
  logic [LVL_W-1:0]  next_lvl;
  logic [LVL_W-1:0]  a_lvl;
  logic              use_head;
  logic [IDX_W-1:0]  a_idx;
  logic [IDX_W-1:0]  a_head_inc;
  logic [IDX_W-1:0]  a_tail_inc;
  logic              a_full;
  logic [ADDR_W-1:0] a_addr;

  logic              ram_we;
  mfd_pkg::job_rec_t ram_wdata;
  logic [mfd_pkg::JOB_W-1:0] ram_rdata;
  mfd_pkg::job_rec_t rd_job;

  logic              reject;
  logic [15:0]       quantum_ext;
  logic [15:0]       remain;

  // Highest priority non-empty level; the lowest index wins.
  always_comb begin
    first_lvl   = '0;
    any_waiting = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        first_lvl   = LVL_W'(i);
        any_waiting = 1'b1;
      end
    end
  end

  // The deepest level re-queues into itself.
  assign next_lvl = ((LVL_W + 1)'(lvl_r) + 1'b1 < (LVL_W + 1)'(LEVELS)) ?
                    LVL_W'(lvl_r + 1'b1) : LVL_W'(LEVELS - 1);

  // One level is addressed per cycle: the request's level on enqueue, the
  // chosen level on dispatch, the level below on re-queue.
  always_comb begin
    if (state_r == mfd_pkg::BK_RESOLVE) begin
      a_lvl = next_lvl;
    end else if (q_req.cmd == mfd_pkg::CMD_ENQUEUE) begin
      a_lvl = LVL_W'(q_req.level);
    end else begin
      a_lvl = first_lvl;
    end
  end

  assign use_head   = (state_r == mfd_pkg::BK_IDLE) && (q_req.cmd == mfd_pkg::CMD_DISPATCH);
  assign a_idx      = use_head ? head_r[a_lvl] : tail_r[a_lvl];
  assign a_head_inc = (head_r[a_lvl] == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r[a_lvl] + 1'b1;
  assign a_tail_inc = (tail_r[a_lvl] == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r[a_lvl] + 1'b1;
  assign a_full     = (cnt_r[a_lvl] == CNT_W'(QUEUE_DEPTH));
  assign a_addr     = ADDR_W'(a_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(a_idx);

  mfd_ram #(
    .WIDTH (mfd_pkg::JOB_W),
    .DEPTH (LEVELS * QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_addr),
    .wdata (ram_wdata),
    .raddr (a_addr),
    .rdata (ram_rdata)
  );

  assign rd_job      = mfd_pkg::job_rec_t'(ram_rdata);
  assign reject      = (rd_job.prn > cfg.total_printers) || (rd_job.scn > cfg.total_scanners) ||
                       (rd_job.mdm > cfg.total_modems) || (rd_job.drv > cfg.total_drives) ||
                       (rd_job.mem > cfg.user_memory_limit);
  assign quantum_ext = {8'd0, cfg.quantum};
  assign remain      = (rd_job.run_time > quantum_ext) ? rd_job.run_time - quantum_ext : 16'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfd_pkg::BK_IDLE: begin
        if (q_valid && (q_req.cmd == mfd_pkg::CMD_DISPATCH) && any_waiting) begin
          state_nxt = mfd_pkg::BK_RESOLVE;
        end
      end
      mfd_pkg::BK_RESOLVE: begin
        state_nxt = mfd_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = mfd_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    lvl_nxt       = lvl_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = q_req.job;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    case (state_r)
      mfd_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_req.cmd == mfd_pkg::CMD_ENQUEUE) begin
            out_valid_nxt = 1'b1;
            if (a_full) begin
              out_res_nxt.status = mfd_pkg::ST_QUEUE_FULL;
            end else begin
              ram_we             = 1'b1;
              tail_nxt[a_lvl]    = a_tail_inc;
              cnt_nxt[a_lvl]     = cnt_r[a_lvl] + 1'b1;
              out_res_nxt.status = mfd_pkg::ST_ENQUEUED;
            end
          end else if (!any_waiting) begin
            out_valid_nxt      = 1'b1;
            out_res_nxt.status = mfd_pkg::ST_NONE_WAITING;
          end else begin
            // Pop now; the record arrives from the store next cycle.
            head_nxt[a_lvl] = a_head_inc;
            cnt_nxt[a_lvl]  = cnt_r[a_lvl] - 1'b1;
            lvl_nxt         = a_lvl;
          end
        end
      end
      mfd_pkg::BK_RESOLVE: begin
        out_valid_nxt            = 1'b1;
        out_res_nxt.job_arrival  = rd_job.arrival;
        out_res_nxt.job_level    = 2'(lvl_r);
        out_res_nxt.job_memory   = rd_job.mem;
        out_res_nxt.job_printers = rd_job.prn;
        out_res_nxt.job_scanners = rd_job.scn;
        out_res_nxt.job_modems   = rd_job.mdm;
        out_res_nxt.job_drives   = rd_job.drv;
        ram_wdata                = rd_job;
        ram_wdata.run_time       = remain;
        if (reject) begin
          out_res_nxt.status        = mfd_pkg::ST_REJECTED;
          out_res_nxt.job_remaining = rd_job.run_time;
        end else if (lvl_r == '0) begin
          out_res_nxt.status        = mfd_pkg::ST_COMPLETED;
        end else begin
          out_res_nxt.job_remaining = remain;
          if (remain == 16'd0) begin
            out_res_nxt.status = mfd_pkg::ST_COMPLETED;
          end else if (a_full) begin
            out_res_nxt.status = mfd_pkg::ST_REQUEUE_DROPPED;
          end else begin
            ram_we             = 1'b1;
            tail_nxt[a_lvl]    = a_tail_inc;
            cnt_nxt[a_lvl]     = cnt_r[a_lvl] + 1'b1;
            out_res_nxt.status = mfd_pkg::ST_DEMOTED;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfd_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      lvl_r       <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `MFD_CHECK(a_resolve_follows_pop, (state_r == mfd_pkg::BK_RESOLVE) |-> $past(q_pop && (q_req.cmd == mfd_pkg::CMD_DISPATCH)), "resolve without a dispatch pop")
  `MFD_CHECK(a_result_has_cause, out_valid_r |-> ($past(q_pop) || $past(state_r == mfd_pkg::BK_RESOLVE)), "result without a request")
  `MFD_CHECK(a_no_pop_while_resolving, (state_r == mfd_pkg::BK_RESOLVE) |=> !$past(q_pop), "request taken during resolve")
  `MFD_CHECK_RST(a_reset_quiet, !rst_n |=> (!out_valid_r && (state_r == mfd_pkg::BK_IDLE)), "activity right after reset")

endmodule

`default_nettype wire

// ----- hdl/multilevel_feedback_dispatcher.sv -----
// Channel   Handshake              Payload
// input     start / busy           in_req  (mfd_pkg::in_req_t)
// result    out_valid strobe       out_res (mfd_pkg::out_res_t)
// config    cfg_we                 cfg_idx, cfg_data
//
// A request is taken into a two-entry queue and waits there until the back end takes it.
// The back end answers an enqueue or an empty dispatch from its idle state. A dispatch
// that pops a job reads the job store, then checks, answers and re-queues it in resolve.
// The result is registered; busy rises while the queue is full.
// Reset empties every level at once; the job store needs no clearing.
// Results last one cycle and cannot be held off by the receiver.
`default_nettype none

module multilevel_feedback_dispatcher #(
  parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH_DEF,
  parameter int LEVELS      = mfd_pkg::LEVELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire mfd_pkg::in_req_t                in_req,
  output logic                                 out_valid,
  output mfd_pkg::out_res_t                    out_res,
  input  wire logic                            cfg_we,
  input  wire logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mfd_pkg::cfg_t   cfg_r, cfg_nxt;
  logic            q_valid;
  logic            q_pop;
  mfd_pkg::q_req_t q_req;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        mfd_pkg::CFG_TOTAL_PRINTERS: cfg_nxt.total_printers    = cfg_data[2:0];
        mfd_pkg::CFG_TOTAL_SCANNERS: cfg_nxt.total_scanners    = cfg_data[2:0];
        mfd_pkg::CFG_TOTAL_MODEMS:   cfg_nxt.total_modems      = cfg_data[2:0];
        mfd_pkg::CFG_TOTAL_DRIVES:   cfg_nxt.total_drives      = cfg_data[2:0];
        mfd_pkg::CFG_USER_MEM_LIMIT: cfg_nxt.user_memory_limit = cfg_data[9:0];
        mfd_pkg::CFG_QUANTUM:        cfg_nxt.quantum           = cfg_data[7:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_printers    <= 3'd2;
      cfg_r.total_scanners    <= 3'd1;
      cfg_r.total_modems      <= 3'd1;
      cfg_r.total_drives      <= 3'd2;
      cfg_r.user_memory_limit <= 10'd960;
      cfg_r.quantum           <= 8'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mfd_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_req  (in_req),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  mfd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVELS      (LEVELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

// ----- tb/sv/multilevel_feedback_dispatcher_test.sv -----
`timescale 1ns / 1ps

import mfd_pkg::*;

class dispatch_checker;
  job_rec_t level_jobs[LEVELS_DEF][$];
  out_res_t awaited_results[$];
  cfg_t cfg;
  int mismatches;

  function new();
    cfg = '{total_printers: 3'd2, total_scanners: 3'd1, total_modems: 3'd1,
            total_drives: 3'd2, user_memory_limit: 10'd960, quantum: 8'd1};
    mismatches = 0;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  function bit push_job(int lvl, job_rec_t j);
    if (level_jobs[lvl].size() >= QUEUE_DEPTH_DEF) return 1'b0;
    level_jobs[lvl].push_back(j);
    return 1'b1;
  endfunction

  // Works out the answer to one accepted request and advances the level queues.
  function void note_request(in_req_t r);
    out_res_t res;
    job_rec_t j;
    int lvl;
    int nxt;
    res = '0;
    if (r.cmd == CMD_ENQUEUE) begin
      j = '{arrival: r.arrival, run_time: r.run_time, mem: r.mem_request,
            prn: r.want_printers, scn: r.want_scanners, mdm: r.want_modems,
            drv: r.want_drives};
      lvl = r.level;
      res.status = push_job(lvl, j) ? ST_ENQUEUED : ST_QUEUE_FULL;
    end else begin
      lvl = 0;
      while (lvl < LEVELS_DEF && level_jobs[lvl].size() == 0) lvl++;
      if (lvl == LEVELS_DEF) begin
        res.status = ST_NONE_WAITING;
      end else begin
        j = level_jobs[lvl].pop_front();
        res.job_arrival  = j.arrival;
        res.job_level    = 2'(lvl);
        res.job_memory   = j.mem;
        res.job_printers = j.prn;
        res.job_scanners = j.scn;
        res.job_modems   = j.mdm;
        res.job_drives   = j.drv;
        if (j.prn > cfg.total_printers || j.scn > cfg.total_scanners ||
            j.mdm > cfg.total_modems || j.drv > cfg.total_drives ||
            j.mem > cfg.user_memory_limit) begin
          res.status = ST_REJECTED;
          res.job_remaining = j.run_time;
        end else if (lvl == 0) begin
          res.status = ST_COMPLETED;
        end else begin
          res.job_remaining = (j.run_time > cfg.quantum) ? j.run_time - cfg.quantum : 16'd0;
          if (res.job_remaining == 16'd0) begin
            res.status = ST_COMPLETED;
          end else begin
            // The lowest level takes its own leftovers back.
            j.run_time = res.job_remaining;
            nxt = (lvl + 1 < LEVELS_DEF) ? lvl + 1 : LEVELS_DEF - 1;
            res.status = push_job(nxt, j) ? ST_DEMOTED : ST_REQUEUE_DROPPED;
          end
        end
      end
    end
    awaited_results.push_back(res);
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("ERROR: %s", msg);
  endtask

  task compare_field(string field, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  task check_result(out_res_t got);
    out_res_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with status %0d and nothing awaited", got.status));
    end else begin
      want = awaited_results.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("job_arrival", got.job_arrival, want.job_arrival);
      compare_field("job_level", got.job_level, want.job_level);
      compare_field("job_remaining", got.job_remaining, want.job_remaining);
      compare_field("job_memory", got.job_memory, want.job_memory);
      compare_field("job_printers", got.job_printers, want.job_printers);
      compare_field("job_scanners", got.job_scanners, want.job_scanners);
      compare_field("job_modems", got.job_modems, want.job_modems);
      compare_field("job_drives", got.job_drives, want.job_drives);
    end
  endtask
endclass

module multilevel_feedback_dispatcher_test;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_req_t in_req;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  dispatch_checker sb = new();
  int burst_left;
  int gap_max;

  multilevel_feedback_dispatcher dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results are checked before the request taken at the same edge is noted,
  // since no result can belong to a request accepted at that very edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_res);
      if (start && !busy) sb.note_request(in_req);
    end
  end

  function automatic in_req_t random_payload();
    logic [63:0] w;
    in_req_t r;
    w = {$urandom, $urandom};
    r = w[$bits(in_req_t)-1:0];
    return r;
  endfunction

  function automatic in_req_t dispatch_req();
    in_req_t r;
    r = random_payload();
    r.cmd = CMD_DISPATCH;
    return r;
  endfunction

  function automatic in_req_t job(input logic [1:0] lvl, input logic [15:0] arr,
                                  input logic [15:0] run, input logic [9:0] mem,
                                  input logic [2:0] p, input logic [2:0] s,
                                  input logic [2:0] m, input logic [2:0] d);
    in_req_t r;
    r = '{cmd: CMD_ENQUEUE, arrival: arr, level: lvl, run_time: run, mem_request: mem,
          want_printers: p, want_scanners: s, want_modems: m, want_drives: d};
    return r;
  endfunction

  // Jobs that fit the current limits reach the demotion path; the rest test rejection.
  function automatic in_req_t make_job(input logic [1:0] lvl, input bit fit);
    in_req_t r;
    int unsigned q;
    r = random_payload();
    r.cmd = CMD_ENQUEUE;
    r.level = lvl;
    q = sb.cfg.quantum;
    if ($urandom_range(7, 0) != 0) r.run_time = 16'($urandom_range(3 * q + 2, 0));
    if (fit) begin
      r.want_printers = 3'($urandom_range(sb.cfg.total_printers, 0));
      r.want_scanners = 3'($urandom_range(sb.cfg.total_scanners, 0));
      r.want_modems   = 3'($urandom_range(sb.cfg.total_modems, 0));
      r.want_drives   = 3'($urandom_range(sb.cfg.total_drives, 0));
      r.mem_request   = 10'($urandom_range(sb.cfg.user_memory_limit, 0));
    end
    return r;
  endfunction

  function automatic cfg_t random_cfg(int kind);
    cfg_t c;
    c.total_printers    = 3'($urandom_range(7, 0));
    c.total_scanners    = 3'($urandom_range(7, 0));
    c.total_modems      = 3'($urandom_range(7, 0));
    c.total_drives      = 3'($urandom_range(7, 0));
    c.user_memory_limit = 10'($urandom_range(1023, 0));
    c.quantum           = 8'($urandom_range(255, 1));
    case (kind)
      0: begin
        c = '{total_printers: 3'd0, total_scanners: 3'd0, total_modems: 3'd0,
              total_drives: 3'd0, user_memory_limit: 10'd0, quantum: 8'd255};
      end
      1: begin
        c = '{total_printers: 3'd7, total_scanners: 3'd7, total_modems: 3'd7,
              total_drives: 3'd7, user_memory_limit: 10'd1023, quantum: 8'd1};
      end
      2: begin
        // A zero quantum never shortens a job, so user jobs keep demoting.
        c.quantum = 8'd0;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Called just after a rising edge; returns just after the edge that took the request.
  task automatic send(input in_req_t r);
    if (gap_max > 0 && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      burst_left = $urandom_range(10, 1);
    end
    if (burst_left > 0) burst_left--;
    start <= 1'b1;
    in_req <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    put_reg(CFG_TOTAL_PRINTERS, CFG_DATA_W'(c.total_printers));
    put_reg(CFG_TOTAL_SCANNERS, CFG_DATA_W'(c.total_scanners));
    put_reg(CFG_TOTAL_MODEMS, CFG_DATA_W'(c.total_modems));
    put_reg(CFG_TOTAL_DRIVES, CFG_DATA_W'(c.total_drives));
    put_reg(CFG_USER_MEM_LIMIT, c.user_memory_limit);
    put_reg(CFG_QUANTUM, CFG_DATA_W'(c.quantum));
    cfg_we <= 1'b0;
    sb.cfg = c;
  endtask

  initial begin
    #2_000_000;
    $display("multilevel_feedback_dispatcher_test failed");
    $finish;
  end

  initial begin
    in_req_t r;
    int p_enq;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    burst_left = 0;
    gap_max = 2;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset limits.
    send(dispatch_req());
    send(job(2'd3, 16'hffff, 16'hffff, 10'd1023, 3'd0, 3'd0, 3'd0, 3'd0));
    send(job(2'd2, 16'h0000, 16'd2, 10'd960, 3'd2, 3'd1, 3'd1, 3'd2));
    send(job(2'd1, 16'h1234, 16'd1, 10'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    send(job(2'd0, 16'h8000, 16'hffff, 10'd512, 3'd7, 3'd7, 3'd7, 3'd7));
    send(job(2'd0, 16'd1, 16'd5, 10'd5, 3'd0, 3'd0, 3'd0, 3'd0));
    send(job(2'd1, 16'd2, 16'd9, 10'd0, 3'd3, 3'd0, 3'd0, 3'd0));
    send(job(2'd1, 16'd3, 16'd0, 10'd0, 3'd0, 3'd2, 3'd0, 3'd0));
    send(job(2'd1, 16'd4, 16'd0, 10'd0, 3'd0, 3'd0, 3'd2, 3'd0));
    send(job(2'd1, 16'd5, 16'd0, 10'd0, 3'd0, 3'd0, 3'd0, 3'd3));
    send(job(2'd1, 16'd6, 16'd0, 10'd961, 3'd0, 3'd0, 3'd0, 3'd0));
    send(job(2'd1, 16'd7, 16'd0, 10'd0, 3'd0, 3'd0, 3'd0, 3'd0));
    repeat (13) send(dispatch_req());
    settle();

    // Fill the lowest level past its depth, then demote jobs into it.
    write_config('{total_printers: 3'd7, total_scanners: 3'd7, total_modems: 3'd7,
                   total_drives: 3'd7, user_memory_limit: 10'd1023, quantum: 8'd3});
    gap_max = 0;
    repeat (QUEUE_DEPTH_DEF + 2) send(make_job(2'd3, 1'b1));
    repeat (3) begin
      r = make_job(2'd2, 1'b1);
      r.run_time = 16'd500;
      send(r);
    end
    repeat (4) send(dispatch_req());
    gap_max = 3;
    repeat (QUEUE_DEPTH_DEF + 1) send(make_job(2'd0, 1'b1));
    repeat (QUEUE_DEPTH_DEF + 8) send(dispatch_req());
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      write_config(random_cfg(ph));
      gap_max = (ph == 1) ? 0 : $urandom_range(7, 1);
      burst_left = 0;
      p_enq = $urandom_range(65, 40);
      repeat (70) begin
        if ($urandom_range(99, 0) < p_enq)
          send(make_job(2'($urandom_range(3, 0)), $urandom_range(4, 0) != 0));
        else
          send(dispatch_req());
      end
      settle();
    end

    if (sb.mismatches == 0)
      $display("multilevel_feedback_dispatcher_test passed");
    else
      $display("multilevel_feedback_dispatcher_test failed");
    $finish;
  end

endmodule
